// ===== src/khufu_block_cipher_defines.svh =====
// Assertion macros for the Khufu cipher engine.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef KHUFU_BLOCK_CIPHER_DEFINES_SVH
`define KHUFU_BLOCK_CIPHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KHUFU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KHUFU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/khufu_pkg.sv =====
package khufu_pkg;

	// Default number of S-box octets (eight rounds each)
	localparam int DEF_NUM_OCTETS = 2;

	// Request op codes
	typedef enum logic [1:0] {
		OP_ENCRYPT     = 2'd0,
		OP_DECRYPT     = 2'd1,
		OP_TABLE_WRITE = 2'd2
	} op_e;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_AUX_KEY_0 = 2'd0,
		CFG_AUX_KEY_1 = 2'd1,
		CFG_AUX_KEY_2 = 2'd2,
		CFG_AUX_KEY_3 = 2'd3
	} cfg_reg_e;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINISH
	} state_e;

	// Request payload
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] left_in;
		logic [31:0] right_in;
		logic        table_select;
		logic [7:0]  table_index;
		logic [31:0] table_word;
	} khufu_req_t;

	// Result payload
	typedef struct packed {
		logic [31:0] left_out;
		logic [31:0] right_out;
	} khufu_res_t;

	// Per-cycle controls for the shared round unit
	typedef struct packed {
		logic       decrypt;    // rotate left before lookup instead of right after
		logic       apply_pend; // fold in the S-box word read last cycle
		logic       pend_left;  // that word goes into the left half
		logic       src_left;   // this round's lookup half is the left one
		logic [4:0] rot_amt;
	} round_ctrl_t;

	// Rotation per round within an octet
	localparam logic [4:0] ROT_AMT [8] = '{
		5'd16, 5'd16, 5'd8, 5'd8, 5'd16, 5'd16, 5'd24, 5'd24
	};

	function automatic logic [31:0] rot_right(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] dbl;
		dbl = {x, x} >> n;
		return dbl[31:0];
	endfunction

	function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] dbl;
		dbl = {x, x} << n;
		return dbl[63:32];
	endfunction

endpackage

// ===== src/khufu_sbox_mem.sv =====
module khufu_sbox_mem
	import khufu_pkg::*;
#(
	parameter int NUM_OCTETS = DEF_NUM_OCTETS,
	localparam int DEPTH = NUM_OCTETS * 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/khufu_round_unit.sv =====
module khufu_round_unit
	import khufu_pkg::*;
(
	input  round_ctrl_t ctrl,
	input  logic [31:0] l,
	input  logic [31:0] r,
	input  logic [31:0] sbox_word,
	output logic [31:0] l_app,
	output logic [31:0] r_app,
	output logic [31:0] l_nxt,
	output logic [31:0] r_nxt,
	output logic [7:0]  lookup_byte
);

	logic [31:0] src;
	logic [31:0] pre_rot;
	logic [31:0] post_rot;

	// Fold in the word fetched for the previous round
	assign l_app = (ctrl.apply_pend && ctrl.pend_left) ? (l ^ sbox_word) : l;
	assign r_app = (ctrl.apply_pend && !ctrl.pend_left) ? (r ^ sbox_word) : r;

	// Decrypt rotates before the lookup, encrypt after it
	assign src         = ctrl.src_left ? l_app : r_app;
	assign pre_rot     = ctrl.decrypt ? rot_left(src, ctrl.rot_amt) : src;
	assign lookup_byte = pre_rot[7:0];
	assign post_rot    = ctrl.decrypt ? pre_rot : rot_right(src, ctrl.rot_amt);

	assign l_nxt = ctrl.src_left ? post_rot : l_app;
	assign r_nxt = ctrl.src_left ? r_app : post_rot;

endmodule

// ===== src/khufu_block_cipher.sv =====
// Khufu 64-bit block cipher engine. Pulse start with a request while busy is
// low. Encrypt and decrypt requests raise busy through the round and finish
// states: one round per cycle through a single round unit fed by the
// registered S-box read port, then a finish state that folds in the last
// S-box word and the output whitening. The result shows on result for
// exactly one cycle with done high and must be taken then; a new request
// may start in that same cycle. S-box table writes give no result; the
// S-box has no reset, so every entry must be written before use. Auxiliary
// keys are written through the cfg port while busy is low.
`include "khufu_block_cipher_defines.svh"

module khufu_block_cipher
	import khufu_pkg::*;
#(
	parameter int NUM_OCTETS = DEF_NUM_OCTETS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  khufu_req_t  req,
	output logic        done,
	output khufu_res_t  result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int OCT_W = (NUM_OCTETS > 1) ? $clog2(NUM_OCTETS) : 1;
	localparam int MEM_AW = $clog2(NUM_OCTETS * 256);
	localparam logic [OCT_W-1:0] LAST_OCTET = OCT_W'(NUM_OCTETS - 1);

	state_e            state_q, state_d;
	logic [2:0]        step_q;
	logic [OCT_W-1:0]  octet_q;
	logic              decrypt_q;
	logic              pend_valid_q;
	logic              pend_left_q;
	logic              done_q;
	logic [31:0]       l_q, r_q;
	logic [31:0]       aux_key_q [4];
	khufu_res_t        res_q;

	logic              accept;
	logic              crypt_req;
	logic              load, advance, finish;
	logic              last_round;
	logic [2:0]        k;
	round_ctrl_t       rctrl;
	logic [31:0]       l_app, r_app, l_nxt, r_nxt;
	logic [7:0]        lookup_byte;
	logic [31:0]       sbox_word;
	logic [OCT_W+7:0]  raddr_full, waddr_full;
	logic              tbl_we;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign crypt_req = (req.op == OP_ENCRYPT) || (req.op == OP_DECRYPT);
	assign cfg_ready = !busy;

	// Round position: encrypt walks octets down, decrypt walks them up
	assign k          = decrypt_q ? ~step_q : step_q;
	assign last_round = (step_q == 3'd7) && (octet_q == (decrypt_q ? LAST_OCTET : '0));

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and step controls
	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		advance = 1'b0;
		finish  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && crypt_req) begin
					load    = 1'b1;
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				advance = 1'b1;
				if (last_round) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				finish  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Round unit controls
	always_comb begin
		rctrl.decrypt    = decrypt_q;
		rctrl.apply_pend = pend_valid_q;
		rctrl.pend_left  = pend_left_q;
		rctrl.src_left   = ~k[0];
		rctrl.rot_amt    = ROT_AMT[k];
	end

	khufu_round_unit u_round (
		.ctrl        (rctrl),
		.l           (l_q),
		.r           (r_q),
		.sbox_word   (sbox_word),
		.l_app       (l_app),
		.r_app       (r_app),
		.l_nxt       (l_nxt),
		.r_nxt       (r_nxt),
		.lookup_byte (lookup_byte)
	);

	// S-box store: table writes while idle, one lookup per round
	assign tbl_we     = accept && (req.op == OP_TABLE_WRITE)
		&& (int'(req.table_select) < NUM_OCTETS);
	assign waddr_full = {OCT_W'(req.table_select), req.table_index};
	assign raddr_full = {octet_q, lookup_byte};

	khufu_sbox_mem #(
		.NUM_OCTETS (NUM_OCTETS)
	) u_sbox (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (waddr_full[MEM_AW-1:0]),
		.wdata (req.table_word),
		.raddr (raddr_full[MEM_AW-1:0]),
		.rdata (sbox_word)
	);

	// Round counters and pending-word tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			octet_q      <= '0;
			decrypt_q    <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_left_q  <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= finish;
			if (load) begin
				step_q       <= '0;
				decrypt_q    <= (req.op == OP_DECRYPT);
				octet_q      <= (req.op == OP_DECRYPT) ? '0 : LAST_OCTET;
				pend_valid_q <= 1'b0;
			end else if (advance) begin
				step_q       <= step_q + 3'd1;
				pend_valid_q <= 1'b1;
				pend_left_q  <= k[0];
				if (step_q == 3'd7) begin
					octet_q <= decrypt_q ? (octet_q + OCT_W'(1)) : (octet_q - OCT_W'(1));
				end
			end
		end
	end

	// Block halves and result register
	always_ff @(posedge clk) begin
		if (load) begin
			l_q <= req.left_in ^ ((req.op == OP_DECRYPT) ? aux_key_q[2] : aux_key_q[0]);
			r_q <= req.right_in ^ ((req.op == OP_DECRYPT) ? aux_key_q[3] : aux_key_q[1]);
		end else if (advance) begin
			l_q <= l_nxt;
			r_q <= r_nxt;
		end
		if (finish) begin
			res_q.left_out  <= l_app ^ (decrypt_q ? aux_key_q[0] : aux_key_q[2]);
			res_q.right_out <= r_app ^ (decrypt_q ? aux_key_q[1] : aux_key_q[3]);
		end
	end

	// Auxiliary key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aux_key_q[0] <= '0;
			aux_key_q[1] <= '0;
			aux_key_q[2] <= '0;
			aux_key_q[3] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_AUX_KEY_0: aux_key_q[0] <= cfg_data;
				CFG_AUX_KEY_1: aux_key_q[1] <= cfg_data;
				CFG_AUX_KEY_2: aux_key_q[2] <= cfg_data;
				CFG_AUX_KEY_3: aux_key_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// Sequencing checks
	`KHUFU_ASSERT_SAME(a_done_when_idle, done_q, state_q == ST_IDLE, "result strobe outside idle")
	`KHUFU_ASSERT_NEXT(a_finish_gives_done, state_q == ST_FINISH, done_q, "finish without result")
	`KHUFU_ASSERT_NEXT(a_start_runs, accept && crypt_req, state_q == ST_ROUND && !pend_valid_q, "cipher request did not start rounds")
	`KHUFU_ASSERT_NEXT(a_last_round_finishes, state_q == ST_ROUND && last_round, state_q == ST_FINISH, "last round did not finish")
	`KHUFU_ASSERT_SAME(a_write_only_idle, tbl_we, state_q == ST_IDLE, "S-box write during a block")

endmodule
